// ----- sv/tsg_pkg.sv -----
// Shared types and constants for the trilinear sample and gradient unit.
// No dependencies; compile first.
package tsg_pkg;

  // Corners of one cell, and corner pairs that differ only in x.
  localparam int unsigned CORNERS = 8;
  localparam int unsigned PAIRS   = 4;

  // Register stages from input to output register.
  localparam int unsigned STAGES = 6;

  // Load control handed to every pipeline stage.
  typedef struct packed {
    logic advance;
    logic valid;
  } pipe_ctrl_t;

endpackage

// ----- sv/tsg_if.sv -----
// Valid/ready channel interfaces for the trilinear sample and gradient unit.
// Query channel carries fractions and corner samples; result channel carries value and gradient.
interface tsg_query_if #(
  parameter int FRAC_BITS   = 8,
  parameter int SAMPLE_BITS = 17
);
  logic                          valid;
  logic                          ready;
  logic [FRAC_BITS-1:0]          frac_x;
  logic [FRAC_BITS-1:0]          frac_y;
  logic [FRAC_BITS-1:0]          frac_z;
  logic signed [SAMPLE_BITS-1:0] corner_000;
  logic signed [SAMPLE_BITS-1:0] corner_100;
  logic signed [SAMPLE_BITS-1:0] corner_010;
  logic signed [SAMPLE_BITS-1:0] corner_110;
  logic signed [SAMPLE_BITS-1:0] corner_001;
  logic signed [SAMPLE_BITS-1:0] corner_101;
  logic signed [SAMPLE_BITS-1:0] corner_011;
  logic signed [SAMPLE_BITS-1:0] corner_111;

  modport source (
    output valid, frac_x, frac_y, frac_z,
    output corner_000, corner_100, corner_010, corner_110,
    output corner_001, corner_101, corner_011, corner_111,
    input  ready
  );
  modport sink (
    input  valid, frac_x, frac_y, frac_z,
    input  corner_000, corner_100, corner_010, corner_110,
    input  corner_001, corner_101, corner_011, corner_111,
    output ready
  );
endinterface

interface tsg_result_if #(
  parameter int FRAC_BITS   = 8,
  parameter int SAMPLE_BITS = 17
);
  logic                                    valid;
  logic                                    ready;
  logic signed [SAMPLE_BITS+FRAC_BITS-1:0] interp_value;
  logic signed [SAMPLE_BITS+FRAC_BITS:0]   grad_x;
  logic signed [SAMPLE_BITS+FRAC_BITS:0]   grad_y;
  logic signed [SAMPLE_BITS+FRAC_BITS:0]   grad_z;

  modport source (
    output valid, interp_value, grad_x, grad_y, grad_z,
    input  ready
  );
  modport sink (
    input  valid, interp_value, grad_x, grad_y, grad_z,
    output ready
  );
endinterface

// ----- sv/tsg_lerp.sv -----
// One registered linear interpolation step: result = base * 2^F + t * diff, exact.
// Depends on tsg_pkg for the stage load control.
module tsg_lerp #(
  parameter int F      = 8,
  parameter int BASE_W = 17,
  parameter int DIFF_W = 18,
  parameter int OUT_W  = 25
) (
  input  logic                      clk,
  input  tsg_pkg::pipe_ctrl_t       ctrl,
  input  logic signed [BASE_W-1:0]  base,
  input  logic signed [DIFF_W-1:0]  diff,
  input  logic        [F-1:0]       t,
  output logic signed [OUT_W-1:0]   result
);
  import tsg_pkg::*;

  localparam int PROD_W = DIFF_W + F + 1;

  logic signed [BASE_W+F-1:0] base_sh;
  logic signed [PROD_W-1:0]   prod;
  logic signed [OUT_W-1:0]    result_next;

  // Fraction is unsigned: prepend a zero so the product stays signed.
  assign base_sh     = {base, {F{1'b0}}};
  assign prod        = PROD_W'(diff) * PROD_W'($signed({1'b0, t}));
  assign result_next = OUT_W'(base_sh) + OUT_W'(prod);

  // Load only real transactions; hold while the pipeline is stalled.
  always_ff @(posedge clk) begin
    if (ctrl.advance && ctrl.valid) begin
      result <= result_next;
    end
  end

endmodule

// ----- sv/trilinear_sample_and_gradient_unit.sv -----
// Trilinear sample and gradient unit: top level with a six-stage pipeline.
// Depends on tsg_pkg, tsg_query_if / tsg_result_if and tsg_lerp.
//
// Each query transaction carries the fractional position inside one voxel
// cell (frac_x/y/z, unsigned, FRAC_BITS fraction bits) and the eight corner
// samples (corner index bit 0 is x, bit 1 is y, bit 2 is z). The matching
// result transaction carries the interpolated value and the three partial
// derivatives of the trilinear field, each with FRAC_BITS fraction bits and
// rounded toward negative infinity. The unit takes one query every clock
// cycle unless a result waits untaken, and holds a result until the result
// side is ready. The work is a cascade of exact lerps, x first, then y, then
// z, each preceded by a subtract stage; the three multiply stages set the
// depth. Stage six is the output register, so a waiting result never blocks
// the queries that are still in flight behind it for longer than the stall
// itself: a stall on the result side freezes the whole pipeline, and query
// ready drops only while the output register holds an untaken result.
// There is no state beyond the pipeline; reset empties it.
module trilinear_sample_and_gradient_unit #(
  parameter int FRAC_BITS   = 8,
  parameter int SAMPLE_BITS = 17
) (
  input  logic        clk,
  input  logic        rst,
  tsg_query_if.sink   query,
  tsg_result_if.source result
);
  import tsg_pkg::*;

  localparam int F      = FRAC_BITS;
  localparam int S      = SAMPLE_BITS;
  // Working widths, each sized for the exact range of its quantity.
  localparam int D_W    = S + 1;          // corner difference along x
  localparam int DD_W   = S + 2;          // difference of x differences along y
  localparam int A_W    = S + F;          // x lerp
  localparam int DA_W   = S + F + 1;      // y difference of x lerps
  localparam int B_W    = S + 2*F;        // xy lerp
  localparam int E_W    = S + F + 1;      // y lerp of x differences
  localparam int DE_W   = S + F + 2;
  localparam int DGY_W  = S + F + 2;
  localparam int G_W    = S + 2*F + 1;    // gradients at scale 2^(2F)
  localparam int V_W    = S + 3*F;        // value at scale 2^(3F)

  // ---------------------------------------------------------------------
  // Pipeline control: one valid bit per stage, one common advance.
  // ---------------------------------------------------------------------
  logic [STAGES-1:0] v;
  logic              advance;
  pipe_ctrl_t        ctrl [STAGES-1];

  assign advance     = !v[STAGES-1] || result.ready;
  assign query.ready = advance;

  assign ctrl[0] = '{advance: advance, valid: query.valid};
  for (genvar k = 1; k < STAGES - 1; k++) begin : g_ctrl
    assign ctrl[k] = '{advance: advance, valid: v[k-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (advance) begin
      v <= {v[STAGES-2:0], query.valid};
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: differences along x for the four (y, z) pairs.
  // Pair index is y + 2z; its corners are 2*pair (x0) and 2*pair+1 (x1).
  // ---------------------------------------------------------------------
  logic signed [S-1:0] corner [CORNERS];
  assign corner[0] = query.corner_000;
  assign corner[1] = query.corner_100;
  assign corner[2] = query.corner_010;
  assign corner[3] = query.corner_110;
  assign corner[4] = query.corner_001;
  assign corner[5] = query.corner_101;
  assign corner[6] = query.corner_011;
  assign corner[7] = query.corner_111;

  logic signed [D_W-1:0] s1_d  [PAIRS];
  logic signed [S-1:0]   s1_c0 [PAIRS];
  logic [F-1:0]          s1_tx, s1_ty, s1_tz;

  for (genvar p = 0; p < PAIRS; p++) begin : g_s1
    always_ff @(posedge clk) begin
      if (ctrl[0].advance && ctrl[0].valid) begin
        s1_d[p]  <= D_W'(corner[2*p+1]) - D_W'(corner[2*p]);
        s1_c0[p] <= corner[2*p];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl[0].advance && ctrl[0].valid) begin
      s1_tx <= query.frac_x;
      s1_ty <= query.frac_y;
      s1_tz <= query.frac_z;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: lerp along x; carry the x differences for grad_x.
  // ---------------------------------------------------------------------
  logic signed [A_W-1:0] s2_a [PAIRS];
  logic signed [D_W-1:0] s2_d [PAIRS];
  logic [F-1:0]          s2_ty, s2_tz;

  for (genvar p = 0; p < PAIRS; p++) begin : g_s2
    tsg_lerp #(.F(F), .BASE_W(S), .DIFF_W(D_W), .OUT_W(A_W)) u_lerp_x (
      .clk    (clk),
      .ctrl   (ctrl[1]),
      .base   (s1_c0[p]),
      .diff   (s1_d[p]),
      .t      (s1_tx),
      .result (s2_a[p])
    );
    always_ff @(posedge clk) begin
      if (ctrl[1].advance && ctrl[1].valid) begin
        s2_d[p] <= s1_d[p];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl[1].advance && ctrl[1].valid) begin
      s2_ty <= s1_ty;
      s2_tz <= s1_tz;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: differences along y, per z layer.
  // ---------------------------------------------------------------------
  logic signed [DA_W-1:0] s3_da [2];
  logic signed [A_W-1:0]  s3_a0 [2];
  logic signed [DD_W-1:0] s3_dd [2];
  logic signed [D_W-1:0]  s3_d0 [2];
  logic [F-1:0]           s3_ty, s3_tz;

  for (genvar z = 0; z < 2; z++) begin : g_s3
    always_ff @(posedge clk) begin
      if (ctrl[2].advance && ctrl[2].valid) begin
        s3_da[z] <= DA_W'(s2_a[2*z+1]) - DA_W'(s2_a[2*z]);
        s3_a0[z] <= s2_a[2*z];
        s3_dd[z] <= DD_W'(s2_d[2*z+1]) - DD_W'(s2_d[2*z]);
        s3_d0[z] <= s2_d[2*z];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl[2].advance && ctrl[2].valid) begin
      s3_ty <= s2_ty;
      s3_tz <= s2_tz;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: lerp along y for the value and for the x gradient.
  // ---------------------------------------------------------------------
  logic signed [B_W-1:0]  s4_b  [2];
  logic signed [E_W-1:0]  s4_e  [2];
  logic signed [DA_W-1:0] s4_da [2];
  logic [F-1:0]           s4_tz;

  for (genvar z = 0; z < 2; z++) begin : g_s4
    tsg_lerp #(.F(F), .BASE_W(A_W), .DIFF_W(DA_W), .OUT_W(B_W)) u_lerp_val_y (
      .clk    (clk),
      .ctrl   (ctrl[3]),
      .base   (s3_a0[z]),
      .diff   (s3_da[z]),
      .t      (s3_ty),
      .result (s4_b[z])
    );
    tsg_lerp #(.F(F), .BASE_W(D_W), .DIFF_W(DD_W), .OUT_W(E_W)) u_lerp_gx_y (
      .clk    (clk),
      .ctrl   (ctrl[3]),
      .base   (s3_d0[z]),
      .diff   (s3_dd[z]),
      .t      (s3_ty),
      .result (s4_e[z])
    );
    always_ff @(posedge clk) begin
      if (ctrl[3].advance && ctrl[3].valid) begin
        s4_da[z] <= s3_da[z];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl[3].advance && ctrl[3].valid) begin
      s4_tz <= s3_tz;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: differences along z. The value difference is grad_z itself.
  // ---------------------------------------------------------------------
  logic signed [G_W-1:0]   s5_gz;
  logic signed [B_W-1:0]   s5_b0;
  logic signed [DE_W-1:0]  s5_de;
  logic signed [E_W-1:0]   s5_e0;
  logic signed [DGY_W-1:0] s5_dgy;
  logic signed [DA_W-1:0]  s5_da0;
  logic [F-1:0]            s5_tz;

  always_ff @(posedge clk) begin
    if (ctrl[4].advance && ctrl[4].valid) begin
      s5_gz  <= G_W'(s4_b[1]) - G_W'(s4_b[0]);
      s5_b0  <= s4_b[0];
      s5_de  <= DE_W'(s4_e[1]) - DE_W'(s4_e[0]);
      s5_e0  <= s4_e[0];
      s5_dgy <= DGY_W'(s4_da[1]) - DGY_W'(s4_da[0]);
      s5_da0 <= s4_da[0];
      s5_tz  <= s4_tz;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 6: lerp along z into the output register.
  // ---------------------------------------------------------------------
  logic signed [V_W-1:0] s6_val;
  logic signed [G_W-1:0] s6_gx, s6_gy, s6_gz;

  tsg_lerp #(.F(F), .BASE_W(B_W), .DIFF_W(G_W), .OUT_W(V_W)) u_lerp_val_z (
    .clk    (clk),
    .ctrl   (pipe_ctrl_t'{advance: advance, valid: v[4]}),
    .base   (s5_b0),
    .diff   (s5_gz),
    .t      (s5_tz),
    .result (s6_val)
  );
  tsg_lerp #(.F(F), .BASE_W(E_W), .DIFF_W(DE_W), .OUT_W(G_W)) u_lerp_gx_z (
    .clk    (clk),
    .ctrl   (pipe_ctrl_t'{advance: advance, valid: v[4]}),
    .base   (s5_e0),
    .diff   (s5_de),
    .t      (s5_tz),
    .result (s6_gx)
  );
  tsg_lerp #(.F(F), .BASE_W(DA_W), .DIFF_W(DGY_W), .OUT_W(G_W)) u_lerp_gy_z (
    .clk    (clk),
    .ctrl   (pipe_ctrl_t'{advance: advance, valid: v[4]}),
    .base   (s5_da0),
    .diff   (s5_dgy),
    .t      (s5_tz),
    .result (s6_gy)
  );

  always_ff @(posedge clk) begin
    if (advance && v[4]) begin
      s6_gz <= s5_gz;
    end
  end

  // Drop the surplus fraction bits: an arithmetic right shift floors.
  assign result.valid        = v[STAGES-1];
  assign result.interp_value = s6_val[V_W-1:2*F];
  assign result.grad_x       = s6_gx[G_W-1:F];
  assign result.grad_y       = s6_gy[G_W-1:F];
  assign result.grad_z       = s6_gz[G_W-1:F];

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // An accepted query occupies stage one on the next edge.
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    query.valid && query.ready |=> v[0])
    else $error("accepted query did not enter the pipeline");

  // Without an accepted query, the number of transactions in flight never grows.
  a_no_invention: assert property (@(posedge clk) disable iff (rst)
    !(query.valid && query.ready) |=> $countones(v) <= $past($countones(v)))
    else $error("transaction appeared in the pipeline without a query");

  // A stall freezes every stage, so nothing is lost or repeated.
  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(v))
    else $error("pipeline moved during a stall");

  // A completed result transaction leaves the output register unless refilled.
  a_result_drains: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.ready && !v[4] |=> !result.valid)
    else $error("result repeated after it was taken");

endmodule

// ----- bench/trilinear_result_checker.sv -----
// Checker for the trilinear sample and gradient unit: predicts every result
// from the accepted query transactions and compares it with the result channel.
// Depends on tsg_query_if / tsg_result_if.
module trilinear_result_checker #(
  parameter int FRAC_BITS   = 8,
  parameter int SAMPLE_BITS = 17
) (
  input  logic  clk,
  input  logic  rst,
  tsg_query_if  query,
  tsg_result_if result,
  output int    mismatches,
  output int    awaiting
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VALUE_W = SAMPLE_BITS + FRAC_BITS;
  localparam int GRAD_W  = VALUE_W + 1;

  typedef struct packed {
    logic signed [VALUE_W-1:0] interp_value;
    logic signed [GRAD_W-1:0]  grad_x;
    logic signed [GRAD_W-1:0]  grad_y;
    logic signed [GRAD_W-1:0]  grad_z;
  } cell_result_t;

  cell_result_t pending_cells[$];
  int           fault_count = 0;

  assign mismatches = fault_count;

  // Exact trilinear sum and the three derivative sums; arithmetic shift floors.
  function automatic cell_result_t trilinear_predict(input longint fx, input longint fy,
                                                     input longint fz,
                                                     input longint corner [8]);
    longint       wt [3][2];
    longint       wyz, wxz, wxy;
    longint       acc_v, acc_x, acc_y, acc_z;
    int           bx, by, bz;
    cell_result_t r;
    wt[0][1] = fx;
    wt[1][1] = fy;
    wt[2][1] = fz;
    wt[0][0] = (longint'(1) << FRAC_BITS) - fx;
    wt[1][0] = (longint'(1) << FRAC_BITS) - fy;
    wt[2][0] = (longint'(1) << FRAC_BITS) - fz;
    acc_v = 0;
    acc_x = 0;
    acc_y = 0;
    acc_z = 0;
    for (int i = 0; i < 8; i++) begin
      bx = i & 1;
      by = (i >> 1) & 1;
      bz = (i >> 2) & 1;
      wyz = wt[1][by] * wt[2][bz];
      wxz = wt[0][bx] * wt[2][bz];
      wxy = wt[0][bx] * wt[1][by];
      acc_v += wt[0][bx] * wyz * corner[i];
      acc_x += bx ? wyz * corner[i] : -(wyz * corner[i]);
      acc_y += by ? wxz * corner[i] : -(wxz * corner[i]);
      acc_z += bz ? wxy * corner[i] : -(wxy * corner[i]);
    end
    r.interp_value = VALUE_W'(acc_v >>> (2 * FRAC_BITS));
    r.grad_x       = GRAD_W'(acc_x >>> FRAC_BITS);
    r.grad_y       = GRAD_W'(acc_y >>> FRAC_BITS);
    r.grad_z       = GRAD_W'(acc_z >>> FRAC_BITS);
    return r;
  endfunction

  task automatic compare_field(input string field, input logic signed [GRAD_W-1:0] want_v,
                               input logic signed [GRAD_W-1:0] got_v);
    if (got_v !== want_v) begin
      fault_count++;
      if (fault_count <= 10)
        $display("mismatch on %s: expected %0d, got %0d", field, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin : watch
    longint       corner [8];
    cell_result_t got;
    cell_result_t want;
    if (!rst) begin
      if (query.valid && query.ready) begin
        corner[0] = longint'(query.corner_000);
        corner[1] = longint'(query.corner_100);
        corner[2] = longint'(query.corner_010);
        corner[3] = longint'(query.corner_110);
        corner[4] = longint'(query.corner_001);
        corner[5] = longint'(query.corner_101);
        corner[6] = longint'(query.corner_011);
        corner[7] = longint'(query.corner_111);
        pending_cells.push_back(trilinear_predict(longint'(query.frac_x),
                                                  longint'(query.frac_y),
                                                  longint'(query.frac_z), corner));
      end
      if (result.valid && result.ready) begin
        got.interp_value = result.interp_value;
        got.grad_x       = result.grad_x;
        got.grad_y       = result.grad_y;
        got.grad_z       = result.grad_z;
        if (pending_cells.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("unexpected result transaction: value %0d", got.interp_value);
        end else begin
          want = pending_cells.pop_front();
          compare_field("interp_value", GRAD_W'(want.interp_value),
                        GRAD_W'(got.interp_value));
          compare_field("grad_x", want.grad_x, got.grad_x);
          compare_field("grad_y", want.grad_y, got.grad_y);
          compare_field("grad_z", want.grad_z, got.grad_z);
        end
      end
      awaiting <= pending_cells.size();
    end
  end

endmodule

// ----- bench/tb_trilinear_sample_and_gradient_unit.sv -----
// Top of the bench for the trilinear sample and gradient unit: clock, reset,
// query stimulus, result back-pressure, watchdog and verdict.
// Depends on tsg_pkg, tsg_query_if / tsg_result_if and trilinear_result_checker.
module tb_trilinear_sample_and_gradient_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_BITS      = 8;
  localparam int SAMPLE_BITS    = 17;
  // Longest legitimate quiet stretch is the long result hold-off (LONG_HOLD)
  // plus a couple of short bursts; leave a wide margin.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 160;
  localparam int SAMPLE_LO      = -32768;
  localparam int SAMPLE_HI      = 65535;

  logic clk;
  logic rst;
  int   fault_total;
  int   cells_in_flight;
  int   idle_cycles;
  bit   calm;            // set for the last part of the run: no idling on either side
  bit   long_hold;       // asks the result side for one long hold-off
  bit   long_hold_done;  // the result side has served the long hold-off

  tsg_query_if  #(.FRAC_BITS(FRAC_BITS), .SAMPLE_BITS(SAMPLE_BITS)) query_ch ();
  tsg_result_if #(.FRAC_BITS(FRAC_BITS), .SAMPLE_BITS(SAMPLE_BITS)) result_ch ();

  trilinear_sample_and_gradient_unit #(
    .FRAC_BITS  (FRAC_BITS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .query (query_ch),
    .result(result_ch)
  );

  trilinear_result_checker #(
    .FRAC_BITS  (FRAC_BITS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) gradient_check (
    .clk       (clk),
    .rst       (rst),
    .query     (query_ch),
    .result    (result_ch),
    .mismatches(fault_total),
    .awaiting  (cells_in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Offer one query transaction and hold it until the unit takes it. Valid
  // stays high afterwards unless an idle burst follows, so back-to-back
  // transactions never see valid dropped and raised in the same step.
  task automatic drive_cell(input int fx, input int fy, input int fz,
                            input int c000, input int c100, input int c010, input int c110,
                            input int c001, input int c101, input int c011, input int c111);
    query_ch.valid      <= 1'b1;
    query_ch.frac_x     <= FRAC_BITS'(fx);
    query_ch.frac_y     <= FRAC_BITS'(fy);
    query_ch.frac_z     <= FRAC_BITS'(fz);
    query_ch.corner_000 <= SAMPLE_BITS'(c000);
    query_ch.corner_100 <= SAMPLE_BITS'(c100);
    query_ch.corner_010 <= SAMPLE_BITS'(c010);
    query_ch.corner_110 <= SAMPLE_BITS'(c110);
    query_ch.corner_001 <= SAMPLE_BITS'(c001);
    query_ch.corner_101 <= SAMPLE_BITS'(c101);
    query_ch.corner_011 <= SAMPLE_BITS'(c011);
    query_ch.corner_111 <= SAMPLE_BITS'(c111);
    do @(posedge clk); while (!query_ch.ready);
    // Idle burst on the query side now and then.
    if (!calm && $urandom_range(0, 4) == 0) begin
      query_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Random cell of one of several shapes: fully random, fractions at the cell
  // faces, a smooth field around one level, or samples around zero so that
  // the floor of small negative sums is exercised.
  task automatic drive_random_cell();
    int fr [3];
    int cs [8];
    int shape;
    int level;
    shape = $urandom_range(0, 9);
    level = int'($urandom_range(0, SAMPLE_HI - SAMPLE_LO)) + SAMPLE_LO;
    for (int a = 0; a < 3; a++) begin
      if (shape == 1 || shape == 2 || shape == 9) begin
        case ($urandom_range(0, 3))
          0:       fr[a] = 0;
          1:       fr[a] = 1;
          2:       fr[a] = 254;
          default: fr[a] = 255;
        endcase
      end else begin
        fr[a] = $urandom_range(0, 255);
      end
    end
    for (int k = 0; k < 8; k++) begin
      if (shape >= 7) begin
        cs[k] = int'($urandom_range(0, 16)) - 8;
      end else if (shape >= 5) begin
        cs[k] = level + int'($urandom_range(0, 1024)) - 512;
        if (cs[k] > SAMPLE_HI) cs[k] = SAMPLE_HI;
        else if (cs[k] < SAMPLE_LO) cs[k] = SAMPLE_LO;
      end else begin
        cs[k] = int'($urandom_range(0, SAMPLE_HI - SAMPLE_LO)) + SAMPLE_LO;
      end
    end
    drive_cell(fr[0], fr[1], fr[2], cs[0], cs[1], cs[2], cs[3], cs[4], cs[5], cs[6], cs[7]);
  endtask

  // Wait until every predicted result has come back. The first edge lets the
  // checker register the transaction accepted on the current one.
  task automatic drain_results();
    do @(posedge clk); while (cells_in_flight != 0);
  endtask

  // Result side: short stall bursts, stretches of steady readiness, and one
  // long hold-off on request so that the pipeline fills and query ready drops.
  initial begin
    long_hold_done = 1'b0;
    result_ch.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (long_hold && !long_hold_done) begin
        result_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_done = 1'b1;
      end else if (calm || $urandom_range(0, 3) != 0) begin
        result_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end else begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  // Watchdog: count cycles in which neither channel completes a transaction.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((query_ch.valid && query_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    calm      = 1'b0;
    long_hold = 1'b0;
    rst       = 1'b1;
    query_ch.valid      <= 1'b0;
    query_ch.frac_x     <= '0;
    query_ch.frac_y     <= '0;
    query_ch.frac_z     <= '0;
    query_ch.corner_000 <= '0;
    query_ch.corner_100 <= '0;
    query_ch.corner_010 <= '0;
    query_ch.corner_110 <= '0;
    query_ch.corner_001 <= '0;
    query_ch.corner_101 <= '0;
    query_ch.corner_011 <= '0;
    query_ch.corner_111 <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed cells: extremes of every field and the floor on negatives.
    drive_cell(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    drive_cell(0, 0, 0, SAMPLE_HI, SAMPLE_HI, SAMPLE_HI, SAMPLE_HI,
               SAMPLE_HI, SAMPLE_HI, SAMPLE_HI, SAMPLE_HI);
    drive_cell(255, 255, 255, SAMPLE_HI, SAMPLE_HI, SAMPLE_HI, SAMPLE_HI,
               SAMPLE_HI, SAMPLE_HI, SAMPLE_HI, SAMPLE_HI);
    drive_cell(0, 0, 0, SAMPLE_LO, SAMPLE_LO, SAMPLE_LO, SAMPLE_LO,
               SAMPLE_LO, SAMPLE_LO, SAMPLE_LO, SAMPLE_LO);
    drive_cell(255, 255, 255, SAMPLE_LO, SAMPLE_LO, SAMPLE_LO, SAMPLE_LO,
               SAMPLE_LO, SAMPLE_LO, SAMPLE_LO, SAMPLE_LO);
    // Steepest slope along each axis, both signs.
    drive_cell(0, 0, 0, SAMPLE_LO, SAMPLE_HI, 0, 0, 0, 0, 0, 0);
    drive_cell(0, 0, 0, SAMPLE_HI, SAMPLE_LO, 0, 0, 0, 0, 0, 0);
    drive_cell(0, 0, 0, SAMPLE_LO, 0, SAMPLE_HI, 0, 0, 0, 0, 0);
    drive_cell(0, 0, 0, SAMPLE_HI, 0, SAMPLE_LO, 0, 0, 0, 0, 0);
    drive_cell(0, 0, 0, SAMPLE_LO, 0, 0, 0, SAMPLE_HI, 0, 0, 0);
    drive_cell(0, 0, 0, SAMPLE_HI, 0, 0, 0, SAMPLE_LO, 0, 0, 0);
    drive_cell(255, 255, 255, 0, 0, 0, 0, 0, 0, SAMPLE_LO, SAMPLE_HI);
    drive_cell(255, 255, 255, 0, 0, 0, 0, 0, 0, SAMPLE_HI, SAMPLE_LO);
    // Small negative sums: the scaling must floor, not truncate toward zero.
    drive_cell(1, 1, 1, -1, -1, -1, -1, -1, -1, -1, -1);
    drive_cell(255, 1, 128, -1, 0, 0, -2, 1, -1, 0, 0);
    drive_cell(128, 128, 128, 10, -20, 30, -40, 50, -60, 70, -80);
    // Checkerboard corners with mixed fractions.
    drive_cell(255, 0, 128, SAMPLE_HI, SAMPLE_LO, SAMPLE_LO, SAMPLE_HI,
               SAMPLE_LO, SAMPLE_HI, SAMPLE_HI, SAMPLE_LO);
    drive_cell(0, 255, 1, SAMPLE_LO, SAMPLE_HI, SAMPLE_HI, SAMPLE_LO,
               SAMPLE_HI, SAMPLE_LO, SAMPLE_LO, SAMPLE_HI);
    // Alternating bit patterns in fractions and samples.
    drive_cell(8'hAA, 8'h55, 8'hAA, 43690, -21846, 43690, -21846,
               21845, -21846, 21845, 43690);
    drive_cell(8'h55, 8'hAA, 8'h55, -21846, 43690, 21845, 43690,
               -21846, 21845, -21846, 21845);

    // First random phase; ask for the long hold-off halfway through while
    // queries keep coming.
    for (int n = 0; n < 600; n++) begin
      if (n == 300) long_hold = 1'b1;
      drive_random_cell();
    end

    // Pause the query side until every result is home.
    query_ch.valid <= 1'b0;
    drain_results();

    for (int n = 0; n < 800; n++) drive_random_cell();

    // Last part: no idling on either side, full throughput.
    calm = 1'b1;
    for (int n = 0; n < 530; n++) drive_random_cell();

    query_ch.valid <= 1'b0;
    drain_results();
    // Allow for any stray result still in the pipeline.
    repeat (4 * tsg_pkg::STAGES) @(posedge clk);

    if (fault_total == 0 && cells_in_flight == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/tsg_pkg.sv
sv/tsg_if.sv
sv/tsg_lerp.sv
sv/trilinear_sample_and_gradient_unit.sv
bench/trilinear_result_checker.sv
bench/tb_trilinear_sample_and_gradient_unit.sv
